// ----- rtl/bc_pkg.sv -----
// ----------------------------------------------------------------------------
// bc_pkg
// Shared widths, result select codes and the command and status bundles
// passed between the binomial coefficient controller and datapath.
// ----------------------------------------------------------------------------
package bc_pkg;

   localparam int OPND_BITS       = 32;
   localparam int RESULT_BITS_DEF = 64;
   localparam int ACC_PAD_BITS    = 64;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ACC,
      RES_SAT
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        setup;
      logic        start_iter;
      logic        mul_lo;
      logic        mul_hi;
      logic        div_load;
      logic        div_step;
      logic        acc_update;
      logic        set_result;
      res_sel_type result_sel;
      logic        publish;
   } bc_cmd_type;

   typedef struct packed {
      logic k_gt_n;
      logic loop_done;
      logic div_last;
      logic quot_ovf;
   } bc_status_type;

endpackage

// ----- rtl/binomial_coefficient.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient
// Exact C(n,k) by the multiplicative method with saturation on overflow.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_n[31:0], req_k[31:0]
//   rsp      out        rsp_valid / rsp_stall  rsp_value[RESULT_BITS-1:0],
//                                              rsp_overflow
//
// One request at a time: j = min(k, n-k) multiply-divide steps, cut short
// at overflow (at most about 34 steps for 64 bits); k > n skips the steps.
// The length of each step is set by the bit-serial divider.
// Reset is synchronous and clears the sequencer and the result valid flag.
// A stalled result beat is held; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module binomial_coefficient #(
   parameter int RESULT_BITS = bc_pkg::RESULT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bc_pkg::OPND_BITS-1:0]  req_n,
   input  logic [bc_pkg::OPND_BITS-1:0]  req_k,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [RESULT_BITS-1:0]        rsp_value,
   output logic                          rsp_overflow
);
   import bc_pkg::*;

   bc_cmd_type    cmd;
   bc_status_type status;

   bc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bc_dpath #(
      .RESULT_BITS (RESULT_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_n        (req_n),
      .req_k        (req_k),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// ----- rtl/bc_dpath.sv -----
// ----------------------------------------------------------------------------
// bc_dpath
// Operand, accumulator, two-step 64x32 multiplier, bit-serial restoring
// divider and result registers of the binomial coefficient unit.
// ----------------------------------------------------------------------------
module bc_dpath #(
   parameter int RESULT_BITS = bc_pkg::RESULT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bc_pkg::bc_cmd_type            cmd,
   output bc_pkg::bc_status_type         status,
   input  logic [bc_pkg::OPND_BITS-1:0]  req_n,
   input  logic [bc_pkg::OPND_BITS-1:0]  req_k,
   output logic [RESULT_BITS-1:0]        rsp_value,
   output logic                          rsp_overflow
);
   import bc_pkg::*;

   localparam int DIV_W  = RESULT_BITS + OPND_BITS;
   localparam int PROD_W = ACC_PAD_BITS + OPND_BITS;
   localparam int CNT_W  = $clog2(DIV_W);

   logic [OPND_BITS-1:0]   n_ff, k_ff, keff_ff, base_ff, i_ff, m_ff, rem_ff;
   logic [OPND_BITS-1:0]   n_minus_k;
   logic [RESULT_BITS-1:0] acc_ff, fin_value_ff, rsp_value_ff;
   logic                   fin_ovf_ff, rsp_overflow_ff;
   logic [2*OPND_BITS-1:0] plo_ff, phi_ff, plo_in, phi_in;
   logic [ACC_PAD_BITS-1:0] acc_pad;
   logic [PROD_W-1:0]      prod;
   logic [DIV_W-1:0]       dvd_ff, dvd_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [OPND_BITS:0]     shifted, diff;
   logic [OPND_BITS-1:0]   rem_in;
   logic [RESULT_BITS-1:0] lim;

   assign lim       = {RESULT_BITS{1'b1}};
   assign n_minus_k = n_ff - k_ff;
   assign acc_pad   = ACC_PAD_BITS'(acc_ff);
   assign plo_in    = acc_pad[OPND_BITS-1:0] * m_ff;
   assign phi_in    = acc_pad[ACC_PAD_BITS-1:OPND_BITS] * m_ff;
   assign prod      = {phi_ff, {OPND_BITS{1'b0}}} + PROD_W'(plo_ff);

   assign shifted = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, i_ff};
   always_comb begin
      if (shifted >= {1'b0, i_ff}) begin
         rem_in = diff[OPND_BITS-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[OPND_BITS-1:0];
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
      end
   end

   assign status.k_gt_n    = k_ff > n_ff;
   assign status.loop_done = i_ff > keff_ff;
   assign status.div_last  = cnt_ff == CNT_W'(DIV_W - 1);
   assign status.quot_ovf  = |dvd_ff[DIV_W-1:RESULT_BITS];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= req_n;
         k_ff <= req_k;
      end
      if (cmd.setup) begin
         if (k_ff > n_minus_k) begin
            keff_ff <= n_minus_k;
            base_ff <= k_ff;
         end else begin
            keff_ff <= k_ff;
            base_ff <= n_minus_k;
         end
         i_ff   <= OPND_BITS'(1);
         acc_ff <= RESULT_BITS'(1);
      end
      if (cmd.start_iter) begin
         m_ff <= base_ff + i_ff;
      end
      if (cmd.mul_lo) begin
         plo_ff <= plo_in;
      end
      if (cmd.mul_hi) begin
         phi_ff <= phi_in;
      end
      if (cmd.div_load) begin
         dvd_ff <= prod[DIV_W-1:0];
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.acc_update) begin
         acc_ff <= dvd_ff[RESULT_BITS-1:0];
         i_ff   <= i_ff + OPND_BITS'(1);
      end
      if (cmd.set_result) begin
         case (cmd.result_sel)
            RES_ZERO: begin
               fin_value_ff <= '0;
               fin_ovf_ff   <= 1'b0;
            end
            RES_ACC: begin
               fin_value_ff <= acc_ff;
               fin_ovf_ff   <= 1'b0;
            end
            RES_SAT: begin
               fin_value_ff <= lim;
               fin_ovf_ff   <= 1'b1;
            end
            default: begin
               fin_value_ff <= lim;
               fin_ovf_ff   <= 1'b1;
            end
         endcase
      end
      if (cmd.publish) begin
         rsp_value_ff    <= fin_value_ff;
         rsp_overflow_ff <= fin_ovf_ff;
      end
   end

   assign rsp_value    = rsp_value_ff;
   assign rsp_overflow = rsp_overflow_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < i_ff)
      else $error("divider remainder not below divisor");

   a_exact_division: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_update |-> rem_ff == '0)
      else $error("partial product not divisible by step index");

   a_acc_nondecreasing: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_update |-> dvd_ff[RESULT_BITS-1:0] >= acc_ff)
      else $error("running coefficient decreased");

endmodule

// ----- rtl/bc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bc_ctrl
// Sequencer for the binomial coefficient unit: setup, per-step multiply and
// divide, saturation check and result handoff.
// ----------------------------------------------------------------------------
module bc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bc_pkg::bc_status_type status,
   output bc_pkg::bc_cmd_type    cmd
);
   import bc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_TEST,
      S_MUL_LO,
      S_MUL_HI,
      S_DIV_LOAD,
      S_DIV,
      S_CHECK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (status.k_gt_n) begin
               cmd.set_result = 1'b1;
               cmd.result_sel = RES_ZERO;
               state_in       = S_FINISH;
            end else begin
               cmd.setup = 1'b1;
               state_in  = S_TEST;
            end
         end
         S_TEST: begin
            if (status.loop_done) begin
               cmd.set_result = 1'b1;
               cmd.result_sel = RES_ACC;
               state_in       = S_FINISH;
            end else begin
               cmd.start_iter = 1'b1;
               state_in       = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.quot_ovf) begin
               cmd.set_result = 1'b1;
               cmd.result_sel = RES_SAT;
               state_in       = S_FINISH;
            end else begin
               cmd.acc_update = 1'b1;
               state_in       = S_TEST;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result beat overwritten while held");

   a_beat_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !cmd.publish) |=> !rsp_valid_ff)
      else $error("result beat repeated after handoff");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SETUP && req_stall)
      else $error("request taken without entering setup");

endmodule

// ----- bench/binomial_coefficient_checker.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_checker
// Watches the request and result channels of the binomial coefficient unit.
// Every accepted request is turned into an expected C(n,k) with its overflow
// flag by an exact multiplicative computation. Every accepted result is
// compared in order against the oldest expectation. Exposes the number of
// expectations still waiting and the mismatch count.
// ----------------------------------------------------------------------------
module binomial_coefficient_checker #(
   parameter int RESULT_BITS = bc_pkg::RESULT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [bc_pkg::OPND_BITS-1:0]  req_n,
   input  logic [bc_pkg::OPND_BITS-1:0]  req_k,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [RESULT_BITS-1:0]        rsp_value,
   input  logic                          rsp_overflow,
   output int                            outstanding,
   output int                            mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [bc_pkg::OPND_BITS-1:0] n;
      logic [bc_pkg::OPND_BITS-1:0] k;
      logic [RESULT_BITS-1:0]       value;
      logic                         overflow;
   } coef_type;

   coef_type coef_due[$];

   initial begin
      outstanding = 0;
      mismatches  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic coef_type choose(input logic [bc_pkg::OPND_BITS-1:0] n,
                                       input logic [bc_pkg::OPND_BITS-1:0] k);
      logic [63:0] lim;
      logic [63:0] acc;
      logic [63:0] kk;
      logic [63:0] i;
      logic [63:0] m;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      logic [63:0] mr;
      logic [63:0] dr;
      coef_type    r;
      lim        = {64{1'b1}} >> (64 - RESULT_BITS);
      r.n        = n;
      r.k        = k;
      r.value    = '0;
      r.overflow = 1'b0;
      if (k > n)
         return r;
      kk = {32'd0, k};
      if (2 * kk > {32'd0, n})
         kk = {32'd0, n} - kk;
      acc = 64'd1;
      for (i = 64'd1; i <= kk; i++) begin
         m = {32'd0, n} - kk + i;
         a = m;
         b = i;
         while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
         end
         mr  = m / a;
         dr  = i / a;
         acc = acc / dr;
         if (acc > lim / mr) begin
            r.value    = lim[RESULT_BITS-1:0];
            r.overflow = 1'b1;
            return r;
         end
         acc = acc * mr;
      end
      r.value = acc[RESULT_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      coef_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (coef_due.size() == 0) begin
               report_mismatch($sformatf("result beat with none due: value=%h overflow=%b",
                                         rsp_value, rsp_overflow));
            end else begin
               want = coef_due.pop_front();
               if (rsp_value !== want.value)
                  report_mismatch($sformatf("n=%0d k=%0d value=%h, predicted %h",
                                            want.n, want.k, rsp_value, want.value));
               if (rsp_overflow !== want.overflow)
                  report_mismatch($sformatf("n=%0d k=%0d overflow=%b, predicted %b",
                                            want.n, want.k, rsp_overflow, want.overflow));
            end
         end
         if (req_valid && !req_stall)
            coef_due.push_back(choose(req_n, req_k));
      end
      outstanding <= coef_due.size();
   end

endmodule

// ----- bench/binomial_coefficient_tb.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_tb
// Drives the binomial coefficient unit with directed corner operands (empty
// and oversized subsets, full-range operands, results at the edge of the
// 64-bit range) followed by a random mix weighted toward small sets and
// short loops. Both channels idle at random; the receiver also holds off
// for a long stretch so the unit backs up, and the sender drains once.
// The checker beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module binomial_coefficient_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RES_W        = bc_pkg::RESULT_BITS_DEF;
   localparam int OPND_W       = bc_pkg::OPND_BITS;
   localparam int RANDOM_BEATS = 1650;
   localparam int HOLD_CYCLES  = 3000;
   localparam int TAIL_CYCLES  = 4000;
   localparam int DIR_COUNT    = 24;

   localparam logic [OPND_W-1:0] DIR_N [DIR_COUNT] = '{
      32'd0, 32'd5, 32'd0, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd10, 32'd67,
      32'd68, 32'd66, 32'd100, 32'd62, 32'h8000_0000, 32'hFFFF_FFFE, 32'd64,
      32'd7, 32'd1000000, 32'hFFFF_FFFF
   };
   localparam logic [OPND_W-1:0] DIR_K [DIR_COUNT] = '{
      32'd0, 32'd0, 32'd5, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'd1,
      32'd2, 32'd3, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1, 32'd5, 32'd33,
      32'd34, 32'd33, 32'd50, 32'd31, 32'h4000_0000, 32'h7FFF_FFFF, 32'd32,
      32'd3, 32'd3, 32'h8000_0000
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OPND_W-1:0] req_n = '0;
   logic [OPND_W-1:0] req_k = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [RES_W-1:0]  rsp_value;
   logic              rsp_overflow;
   int                outstanding;
   int                mismatches;
   bit                send_idle_en = 1'b1;
   bit                recv_idle_en = 1'b1;
   bit                hold_go = 1'b0;

   binomial_coefficient #(
      .RESULT_BITS(RES_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_n(req_n),
      .req_k(req_k),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_overflow(rsp_overflow)
   );

   binomial_coefficient_checker #(
      .RESULT_BITS(RES_W)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_n(req_n),
      .req_k(req_k),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_overflow(rsp_overflow),
      .outstanding(outstanding),
      .mismatches(mismatches)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_beat(input logic [OPND_W-1:0] n, input logic [OPND_W-1:0] k);
      @(negedge clock);
      while (send_idle_en && $urandom_range(99, 0) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_n     <= n;
      req_k     <= k;
      do @(posedge clock); while (req_stall);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= recv_idle_en && ($urandom_range(99, 0) < 16);
      end
   end

   initial begin
      logic [OPND_W-1:0] n;
      logic [OPND_W-1:0] k;
      int                pick;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_N[i])
         send_beat(DIR_N[i], DIR_K[i]);

      for (int b = 0; b < RANDOM_BEATS; b++) begin
         if (b == 400)
            hold_go = 1'b1;
         if (b == 700) begin
            send_idle_en = 1'b0;
            recv_idle_en = 1'b0;
         end
         if (b == 1000) begin
            send_idle_en = 1'b1;
            recv_idle_en = 1'b1;
         end
         if (b == 1200) begin
            @(negedge clock);
            req_valid <= 1'b0;
            wait (outstanding == 0);
         end
         // keep beats short while the result side is held off
         if (b >= 400 && b < 420) begin
            n = $urandom;
            k = $urandom_range(3, 0);
         end else begin
            pick = $urandom_range(99, 0);
            if (pick < 25) begin
               n = $urandom_range(70, 0);
               k = $urandom_range(n + 2, 0);
            end else if (pick < 45) begin
               n = $urandom_range(65535, 0);
               k = $urandom_range(8, 0);
               if ($urandom_range(1, 0))
                  k = n - k;
            end else if (pick < 65) begin
               n = $urandom;
               k = $urandom;
            end else if (pick < 80) begin
               n = $urandom;
               k = $urandom_range(5, 0);
               if ($urandom_range(1, 0))
                  k = n - k;
            end else begin
               n = $urandom;
               k = $urandom_range(n, 0);
            end
         end
         send_beat(n, k);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("binomial_coefficient test passed");
      else
         $display("binomial_coefficient test failed");
      $finish;
   end

   initial begin
      #80ms;
      $display("binomial_coefficient test failed");
      $finish;
   end

endmodule
